// ===== rtl/core/decimal_list_parser_dedup_macros.svh =====
// Assertion macros used by the decimal list parser datapath.
`ifndef DECIMAL_LIST_PARSER_DEDUP_MACROS_SVH
`define DECIMAL_LIST_PARSER_DEDUP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dlpd_pkg.sv =====
// Package with types, codes and constants of the decimal list parser.
package dlpd_pkg;

  localparam int MAX_ENTRIES_DEF  = 32;
  localparam int MAX_TEXT_LEN_DEF = 256;

  localparam logic [5:0]  CAPACITY_RESET = 6'd32;
  localparam logic [19:0] VALUE_MAX      = 20'd65535;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic set_full;
    logic commit;
    logic final_load;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic is_end;
    logic scan_done;
    logic hit;
    logic full;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/dlpd_in_if.sv =====
// Input character channel of the decimal list parser.
interface dlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/core/dlpd_out_if.sv =====
// Result channel of the decimal list parser.
interface dlpd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] value;
  logic [4:0]  slot;
  logic [1:0]  status;
  logic [5:0]  count;
  logic        last_of_run;

  modport source (output valid, output kind, output value, output slot, output status,
                  output count, output last_of_run, input ready);
  modport sink   (input valid, input kind, input value, input slot, input status,
                  input count, input last_of_run, output ready);
endinterface

// ===== rtl/core/dlpd_cfg_if.sv =====
// Capacity register write channel of the decimal list parser.
interface dlpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/core/dlpd_datapath.sv =====
// Datapath of the decimal list parser: parse state, value store, scan and result register.
`include "decimal_list_parser_dedup_macros.svh"

module dlpd_datapath #(
  parameter int MAX_ENTRIES  = dlpd_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_TEXT_LEN = dlpd_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dlpd_cfg_if.sink         cfg_i,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_text_i,
  input  dlpd_pkg::cmd_t   cmd_i,
  output dlpd_pkg::sts_t   sts_o,
  dlpd_out_if.source       out_o
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CAPW = (CW > 6) ? CW : 6;
  localparam int LW   = $clog2(MAX_TEXT_LEN + 2);
  localparam logic [LW-1:0]   LEN_LIM = LW'(MAX_TEXT_LEN);
  localparam logic [CAPW-1:0] CAP_MAX = CAPW'(MAX_ENTRIES);

  logic [15:0]       mem [MAX_ENTRIES];

  logic [15:0]       acc_q, acc_d;
  logic              innum_q, innum_d;
  dlpd_pkg::status_e sticky_q, sticky_d;
  logic [LW-1:0]     len_q, len_d;
  logic [CW-1:0]     count_q, count_d;
  logic [5:0]        cap_q;
  logic [CW-1:0]     idx_q, idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;

  logic [15:0]       pend_val_q;
  logic [15:0]       rd_data_q;
  logic              out_kind_q;
  logic [15:0]       out_value_q;
  logic [4:0]        out_slot_q;
  dlpd_pkg::status_e out_status_q;
  logic [5:0]        out_count_q;
  logic              out_last_q;

  logic              is_digit;
  logic              is_sep;
  logic [19:0]       prod;
  logic              rd_en;
  logic [CAPW-1:0]   cnt_ext;
  logic [CAPW-1:0]   cap_ext;
  logic [CAPW-1:0]   cap_eff;
  logic [LW-1:0]     len_a;
  logic              too_long;
  logic              parse_ok;

  assign cfg_i.ready = 1'b1;

  assign is_digit = (char_code_i >= dlpd_pkg::CHAR_ZERO) && (char_code_i <= dlpd_pkg::CHAR_NINE);
  assign is_sep   = (char_code_i == dlpd_pkg::CHAR_COMMA) || (char_code_i == dlpd_pkg::CHAR_SEMI)
                 || (char_code_i == dlpd_pkg::CHAR_SPACE) || (char_code_i == dlpd_pkg::CHAR_TAB)
                 || (char_code_i == dlpd_pkg::CHAR_CR) || (char_code_i == dlpd_pkg::CHAR_LF);
  assign prod = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
              + {16'd0, 4'(char_code_i - dlpd_pkg::CHAR_ZERO)};

  assign len_a    = (len_q <= LEN_LIM) ? len_q + LW'(1) : len_q;
  assign too_long = len_a > LEN_LIM;
  assign parse_ok = !too_long && (sticky_q == dlpd_pkg::STATUS_OK);

  assign cnt_ext = CAPW'(count_q);
  assign cap_ext = CAPW'(cap_q);
  assign cap_eff = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;

  assign rd_en = cmd_i.scan && !hit_q && (idx_q < count_q);

  assign sts_o.is_end    = end_of_text_i;
  assign sts_o.finish    = innum_q && (end_of_text_i ? (sticky_q == dlpd_pkg::STATUS_OK)
                                                     : (parse_ok && is_sep));
  assign sts_o.scan_done = !rd_pend_q && (hit_q || (idx_q == count_q));
  assign sts_o.hit       = hit_q;
  assign sts_o.full      = cnt_ext >= cap_eff;
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    acc_d       = acc_q;
    innum_d     = innum_q;
    sticky_d    = sticky_q;
    len_d       = len_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_pend_d   = rd_pend_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_o.ready;

    if (cmd_i.accept) begin
      if (end_of_text_i) begin
        acc_d   = '0;
        innum_d = 1'b0;
      end else begin
        len_d = len_a;
        if (too_long) begin
          sticky_d = dlpd_pkg::STATUS_INVALID;
          acc_d    = '0;
          innum_d  = 1'b0;
        end else if (sticky_q == dlpd_pkg::STATUS_OK) begin
          if (is_digit) begin
            if (prod > dlpd_pkg::VALUE_MAX) begin
              sticky_d = dlpd_pkg::STATUS_INVALID;
              acc_d    = '0;
              innum_d  = 1'b0;
            end else begin
              acc_d   = prod[15:0];
              innum_d = 1'b1;
            end
          end else if (is_sep) begin
            acc_d   = '0;
            innum_d = 1'b0;
          end else begin
            sticky_d = dlpd_pkg::STATUS_INVALID;
            acc_d    = '0;
            innum_d  = 1'b0;
          end
        end
      end
      idx_d     = '0;
      rd_pend_d = 1'b0;
      hit_d     = 1'b0;
    end

    if (cmd_i.scan) begin
      rd_pend_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + CW'(1);
      end
      if (rd_pend_q && (rd_data_q == pend_val_q)) begin
        hit_d = 1'b1;
      end
    end

    if (cmd_i.set_full) begin
      sticky_d = dlpd_pkg::STATUS_FULL;
    end

    if (cmd_i.commit) begin
      count_d     = count_q + CW'(1);
      out_valid_d = 1'b1;
    end

    if (cmd_i.final_load) begin
      count_d     = '0;
      sticky_d    = dlpd_pkg::STATUS_OK;
      len_d       = '0;
      acc_d       = '0;
      innum_d     = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      innum_q     <= 1'b0;
      sticky_q    <= dlpd_pkg::STATUS_OK;
      len_q       <= '0;
      count_q     <= '0;
      cap_q       <= dlpd_pkg::CAPACITY_RESET;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      innum_q     <= innum_d;
      sticky_q    <= sticky_d;
      len_q       <= len_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[count_q[AW-1:0]] <= pend_val_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.finish) begin
      pend_val_q <= acc_q;
    end
    if (cmd_i.commit) begin
      out_kind_q   <= dlpd_pkg::KIND_VALUE;
      out_value_q  <= pend_val_q;
      out_slot_q   <= cnt_ext[4:0];
      out_status_q <= dlpd_pkg::STATUS_OK;
      out_count_q  <= '0;
      out_last_q   <= cmd_i.last;
    end else if (cmd_i.final_load) begin
      out_kind_q   <= dlpd_pkg::KIND_FINAL;
      out_value_q  <= '0;
      out_slot_q   <= '0;
      out_status_q <= sticky_q;
      out_count_q  <= (sticky_q == dlpd_pkg::STATUS_OK) ? cnt_ext[5:0] : 6'd0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.value       = out_value_q;
  assign out_o.slot        = out_slot_q;
  assign out_o.status      = out_status_q;
  assign out_o.count       = out_count_q;
  assign out_o.last_of_run = out_last_q;

  `DLPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES), "stored count past depth")
  `DLPD_ASSERT_NOW(a_commit_new, cmd_i.commit, !hit_q && !sts_o.full, "stored a duplicate or past capacity")
  `DLPD_ASSERT_NOW(a_scan_clean, cmd_i.scan, sticky_q == dlpd_pkg::STATUS_OK, "scan with error set")
  `DLPD_ASSERT_NEXT(a_final_clear, cmd_i.final_load, (count_q == '0) && (len_q == '0), "text state kept")

endmodule

// ===== rtl/core/dlpd_ctrl.sv =====
// Controller of the decimal list parser: sequences accept, list scan, store and final status.
module dlpd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dlpd_pkg::sts_t sts_i,
  output dlpd_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STORE,
    S_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   pend_end_q, pend_end_d;
  state_e after_store;

  assign after_store = pend_end_q ? S_FINAL : S_IDLE;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    pend_end_d = pend_end_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.finish) begin
            state_d    = S_SCAN;
            pend_end_d = sts_i.is_end;
          end else if (sts_i.is_end) begin
            state_d = S_FINAL;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        if (sts_i.hit) begin
          state_d = after_store;
        end else if (sts_i.full) begin
          cmd_o.set_full = 1'b1;
          state_d        = after_store;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          cmd_o.last   = !pend_end_q;
          state_d      = after_store;
        end
      end
      S_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.final_load = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_end_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_end_q <= pend_end_d;
    end
  end

endmodule

// ===== rtl/core/decimal_list_parser_dedup.sv =====
// Flow: a digit, a bad byte or a separator with no pending number is taken in S_IDLE alone.
// A number that ends goes on to S_SCAN and S_STORE: the stored list is scanned one entry a
// cycle through the single read port; an end item adds S_FINAL for status. S_STORE (to commit)
// and S_FINAL wait for a free result register; no new character is taken outside S_IDLE.
// Reset (rst_ni low, asynchronous): list empty, no error, capacity 32, result register empty;
// the value store is not cleared, there is no clearing pass.
module decimal_list_parser_dedup #(
  parameter int MAX_ENTRIES  = dlpd_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_TEXT_LEN = dlpd_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlpd_cfg_if.sink   cfg_i,
  dlpd_in_if.sink    in_i,
  dlpd_out_if.source out_o
);

  dlpd_pkg::cmd_t cmd;
  dlpd_pkg::sts_t sts;
  logic           in_ready;

  assign in_i.ready = in_ready;

  dlpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpd_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .char_code_i   (in_i.char_code),
    .end_of_text_i (in_i.end_of_text),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_o         (out_o)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for decimal_list_parser_dedup: random texts against a tracking list model.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_ENTRIES  = dlpd_pkg::MAX_ENTRIES_DEF;
  localparam int MAX_TEXT_LEN = dlpd_pkg::MAX_TEXT_LEN_DEF;
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;
  localparam int RANDOM_ITEMS_PER_PHASE = 110;

  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } char_word_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       value;
    logic [4:0]        slot;
    dlpd_pkg::status_e status;
    logic [5:0]        count;
    logic              last_of_run;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid     = 1'b0;
  logic [7:0] in_code      = 8'h00;
  logic       in_eot       = 1'b0;
  logic       in_fire      = 1'b0;
  logic       res_ready    = 1'b0;
  logic       cfg_valid    = 1'b0;
  logic [5:0] cfg_capacity = 6'd0;

  int idle_pct = 26;
  int n_errors = 0;
  int unsigned items_queued = 0;

  char_word_t pending_chars[$];
  result_t    parsed_results[$];

  // list tracking state
  logic [15:0]       list_vals [MAX_ENTRIES];
  int unsigned       list_count   = 0;
  int unsigned       acc          = 0;
  int unsigned       text_len     = 0;
  bit                in_num       = 1'b0;
  dlpd_pkg::status_e err_st       = dlpd_pkg::STATUS_OK;
  logic [5:0]        capacity_reg = dlpd_pkg::CAPACITY_RESET;

  dlpd_cfg_if cfg_bus ();
  dlpd_in_if  char_bus ();
  dlpd_out_if res_bus ();

  assign cfg_bus.valid        = cfg_valid;
  assign cfg_bus.capacity     = cfg_capacity;
  assign char_bus.valid       = in_valid;
  assign char_bus.char_code   = in_code;
  assign char_bus.end_of_text = in_eot;
  assign res_bus.ready        = res_ready;

  decimal_list_parser_dedup dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus.sink),
    .in_i   (char_bus.sink),
    .out_o  (res_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  task automatic close_number(output bit stored, output result_t r);
    int unsigned v;
    int unsigned cap;
    bit dup;
    v      = acc;
    cap    = (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : capacity_reg;
    in_num = 1'b0;
    acc    = 0;
    stored = 1'b0;
    dup    = 1'b0;
    r      = '0;
    for (int i = 0; i < list_count; i++) begin
      if (list_vals[i] == v[15:0]) dup = 1'b1;
    end
    if (dup) return;
    if (list_count >= cap) begin
      err_st = dlpd_pkg::STATUS_FULL;
      return;
    end
    list_vals[list_count] = v[15:0];
    r.kind   = dlpd_pkg::KIND_VALUE;
    r.value  = v[15:0];
    r.slot   = list_count[4:0];
    r.status = dlpd_pkg::STATUS_OK;
    list_count++;
    stored = 1'b1;
  endtask

  task automatic parse_char(logic [7:0] code, logic eot);
    result_t r [2];
    int n;
    bit got;
    n = 0;
    if (eot) begin
      if (err_st == dlpd_pkg::STATUS_OK && in_num) begin
        close_number(got, r[0]);
        if (got) n = 1;
      end
      r[n]        = '0;
      r[n].kind   = dlpd_pkg::KIND_FINAL;
      r[n].status = err_st;
      r[n].count  = (err_st == dlpd_pkg::STATUS_OK) ? list_count[5:0] : 6'd0;
      n++;
      list_count = 0;
      acc        = 0;
      in_num     = 1'b0;
      err_st     = dlpd_pkg::STATUS_OK;
      text_len   = 0;
    end else begin
      if (text_len <= MAX_TEXT_LEN) text_len++;
      if (text_len > MAX_TEXT_LEN) begin
        err_st = dlpd_pkg::STATUS_INVALID;
        in_num = 1'b0;
        acc    = 0;
      end
      if (err_st == dlpd_pkg::STATUS_OK) begin
        if (code >= dlpd_pkg::CHAR_ZERO && code <= dlpd_pkg::CHAR_NINE) begin
          acc    = acc * 10 + (code - dlpd_pkg::CHAR_ZERO);
          in_num = 1'b1;
          if (acc > dlpd_pkg::VALUE_MAX) begin
            err_st = dlpd_pkg::STATUS_INVALID;
            in_num = 1'b0;
            acc    = 0;
          end
        end else if (code inside {dlpd_pkg::CHAR_COMMA, dlpd_pkg::CHAR_SEMI,
                                  dlpd_pkg::CHAR_SPACE, dlpd_pkg::CHAR_TAB,
                                  dlpd_pkg::CHAR_CR, dlpd_pkg::CHAR_LF}) begin
          if (in_num) begin
            close_number(got, r[0]);
            if (got) n = 1;
          end
        end else begin
          err_st = dlpd_pkg::STATUS_INVALID;
          in_num = 1'b0;
          acc    = 0;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r[i].last_of_run = (i == n - 1);
      parsed_results.push_back(r[i]);
    end
  endtask

  always @(negedge clk) begin : drive_chars
    char_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
        w = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_code  <= w.code;
        in_eot   <= w.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t e;
    in_fire <= rst_n && in_valid && char_bus.ready;
    if (rst_n) begin
      if (res_bus.valid && res_ready) begin
        if (parsed_results.size() == 0) begin
          report_mismatch("word with none pending, value", 64'(res_bus.value), 64'd0);
        end else begin
          e = parsed_results.pop_front();
          if (res_bus.kind != e.kind) begin
            report_mismatch("kind", 64'(res_bus.kind), 64'(e.kind));
          end
          if (res_bus.value != e.value) begin
            report_mismatch("value", 64'(res_bus.value), 64'(e.value));
          end
          if (res_bus.slot != e.slot) begin
            report_mismatch("slot", 64'(res_bus.slot), 64'(e.slot));
          end
          if (res_bus.status != e.status) begin
            report_mismatch("status", 64'(res_bus.status), 64'(e.status));
          end
          if (res_bus.count != e.count) begin
            report_mismatch("count", 64'(res_bus.count), 64'(e.count));
          end
          if (res_bus.last_of_run != e.last_of_run) begin
            report_mismatch("last_of_run", 64'(res_bus.last_of_run), 64'(e.last_of_run));
          end
        end
      end
      if (in_valid && char_bus.ready) parse_char(in_code, in_eot);
    end
  end

  task automatic push_byte(logic [7:0] b);
    pending_chars.push_back('{code: b, eot: 1'b0});
    items_queued++;
  endtask

  task automatic push_end();
    pending_chars.push_back('{code: 8'($urandom_range(255)), eot: 1'b1});
    items_queued++;
  endtask

  task automatic push_string(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_sep();
    case ($urandom_range(5))
      0: push_byte(dlpd_pkg::CHAR_COMMA);
      1: push_byte(dlpd_pkg::CHAR_SEMI);
      2: push_byte(dlpd_pkg::CHAR_SPACE);
      3: push_byte(dlpd_pkg::CHAR_TAB);
      4: push_byte(dlpd_pkg::CHAR_CR);
      default: push_byte(dlpd_pkg::CHAR_LF);
    endcase
  endtask

  task automatic push_long_text(int len, int maxd);
    int run;
    run = 0;
    for (int i = 0; i < len; i++) begin
      if (run > 0 && (run >= maxd || $urandom_range(2) == 0)) begin
        push_sep();
        run = 0;
      end else begin
        push_byte(8'(dlpd_pkg::CHAR_ZERO + $urandom_range(9)));
        run++;
      end
    end
    push_end();
  endtask

  task automatic push_random_text();
    int unsigned kind;
    int unsigned nums;
    int unsigned pool;
    int unsigned bad_at;
    int unsigned noise_pct;
    int unsigned v;
    kind = $urandom_range(99);
    if (kind >= 94) begin
      repeat ($urandom_range(3)) push_sep();
      push_end();
      return;
    end
    if (kind >= 88) begin
      push_long_text($urandom_range(250, 290), $urandom_range(1, 3));
      return;
    end
    nums      = ($urandom_range(7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
    pool      = $urandom_range(2);
    bad_at    = (kind >= 60 && kind < 72) ? $urandom_range(nums - 1) : nums;
    noise_pct = (kind >= 72) ? 15 : 0;
    for (int i = 0; i < nums; i++) begin
      case (pool)
        0: v = $urandom_range(15);
        1: v = $urandom_range(65535);
        default: v = $urandom_range(1) ? 65535 - $urandom_range(3) : $urandom_range(3);
      endcase
      if (i == bad_at) v = $urandom_range(65536, 999999);
      if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) push_byte(dlpd_pkg::CHAR_ZERO);
      push_string($sformatf("%0d", v));
      if ($urandom_range(99) < noise_pct) push_byte(8'($urandom_range(255)));
      if (i < nums - 1 || $urandom_range(1)) begin
        repeat ($urandom_range(1, 2)) push_sep();
      end
    end
    push_end();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || parsed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [5:0] v);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= v;
    do @(posedge clk);
    while (!cfg_bus.ready);
    capacity_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [5:0] caps [8];
    int unsigned target;
    caps = '{6'd63, 6'd32, 6'd2, 6'd0, 6'd5, 6'd1, 6'd33, 6'd32};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every separator, duplicates, number pending at the end, extremes
    push_string("0,65535\t0 7;\n7\r9");
    push_end();
    push_string("65536");
    push_end();
    push_string("4a");
    push_end();
    push_byte(8'h00);
    push_end();
    push_end();
    wait_drained();

    set_capacity(6'd1);
    push_string("5,6");
    push_end();
    wait_drained();

    set_capacity(6'd0);
    push_string("8");
    push_end();
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity((ph == 7) ? 6'($urandom_range(63)) : caps[ph]);
      idle_pct = (ph == 1) ? 0 : 26;
      if (ph == 0) push_long_text(MAX_TEXT_LEN + 1, 2);
      if (ph == 1) push_long_text(MAX_TEXT_LEN, 1);
      target = items_queued + RANDOM_ITEMS_PER_PHASE;
      while (items_queued < target) push_random_text();
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
